// ----- hw/rtl/jslp_pkg.sv -----
// Package for the jog soft limit predictor.
// Holds the word types, register indexes and status codes shared by all files.
// No dependencies.
package jslp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT_EN = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_X_LOW    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_X_HIGH   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_LOW    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_HIGH   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Z_LOW    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Z_HIGH   = 3'd6;

  // Item operation codes.
  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_JOG    = 1'b1;

  // Reported machine states.
  localparam logic [1:0] MS_IDLE    = 2'd1;
  localparam logic [1:0] MS_JOGGING = 2'd2;

  typedef struct packed {
    logic               operation;
    logic               link_up;
    logic [1:0]         machine_state;
    logic signed [31:0] report_x;
    logic signed [31:0] report_y;
    logic signed [31:0] report_z;
    logic               jog_absolute;
    logic [2:0]         axis_mask;
    logic signed [31:0] jog_x;
    logic signed [31:0] jog_y;
    logic signed [31:0] jog_z;
    logic [19:0]        feed_rate;
  } jslp_in_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         sent_mask;
    logic               sent_absolute;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic [19:0]        feed_out;
    logic signed [31:0] pred_pos_x;
    logic signed [31:0] pred_pos_y;
    logic signed [31:0] pred_pos_z;
    logic [15:0]        pending_jobs;
    logic               prediction_valid;
  } jslp_out_t;

endpackage

// ----- hw/rtl/jslp_in_if.sv -----
// Valid/ready channel that carries one input word of the jog predictor.
// Depends on jslp_pkg for the word type.
interface jslp_in_if import jslp_pkg::*; ();
  logic     valid;
  logic     ready;
  jslp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/jslp_out_if.sv -----
// Valid/ready channel that carries one result word of the jog predictor.
// Depends on jslp_pkg for the word type.
interface jslp_out_if import jslp_pkg::*; ();
  logic      valid;
  logic      ready;
  jslp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/jslp_axis.sv -----
// Per-axis arithmetic: predicted position, jog target with soft limit clamp,
// delta, and the pending offset candidates for status and jog updates.
// Depends on jslp_pkg.
module jslp_axis import jslp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic signed [POSITION_BITS-1:0] anchor_i,
  input  logic signed [POSITION_BITS-1:0] pending_i,
  input  logic signed [31:0]              report_i,
  input  logic signed [31:0]              cmd_i,
  input  logic signed [31:0]              lim_a_i,
  input  logic signed [31:0]              lim_b_i,
  input  logic                            absolute_i,
  input  logic                            req_i,
  input  logic                            lim_en_i,
  output logic signed [POSITION_BITS-1:0] rep_o,
  output logic signed [POSITION_BITS-1:0] shift_o,
  output logic signed [POSITION_BITS-1:0] pend_jog_o,
  output logic                            sent_o,
  output logic signed [31:0]              move_o
);

  localparam int unsigned XW = (POSITION_BITS > 32) ? POSITION_BITS : 32;
  localparam int unsigned W  = XW + 2;
  localparam logic signed [W-1:0] PMAX =
    {{(W-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] PMIN =
    {{(W-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

  function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v > PMAX) begin
      r = PMAX;
    end else if (v < PMIN) begin
      r = PMIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic signed [W-1:0] sum_ap, pred, cmd_w, raw, tgt0, tgt;
  logic signed [W-1:0] lim_a, lim_b, lo, hi, delta, delta_sat;
  logic signed [W-1:0] rep_w, shift_w, pend_jog_w;

  assign sum_ap = W'(anchor_i) + W'(pending_i);
  assign pred   = sat(sum_ap);
  assign cmd_w  = W'(cmd_i);
  assign raw    = absolute_i ? cmd_w : pred + cmd_w;
  assign tgt0   = sat(raw);

  assign lim_a = W'(lim_a_i);
  assign lim_b = W'(lim_b_i);
  assign lo    = (lim_a > lim_b) ? lim_b : lim_a;
  assign hi    = (lim_a > lim_b) ? lim_a : lim_b;

  // From outside the range only moves that head back toward it are allowed.
  always_comb begin
    tgt = tgt0;
    if (lim_en_i) begin
      if (pred < lo) begin
        if (tgt0 <= pred) begin
          tgt = pred;
        end else if (tgt0 > hi) begin
          tgt = hi;
        end
      end else if (pred > hi) begin
        if (tgt0 >= pred) begin
          tgt = pred;
        end else if (tgt0 < lo) begin
          tgt = lo;
        end
      end else if (tgt0 < lo) begin
        tgt = lo;
      end else if (tgt0 > hi) begin
        tgt = hi;
      end
    end
  end

  assign delta     = tgt - pred;
  assign delta_sat = sat(delta);
  assign sent_o    = req_i && (delta != '0);
  assign move_o    = absolute_i ? tgt[31:0] : delta_sat[31:0];

  assign rep_w      = sat(W'(report_i));
  assign shift_w    = sat(sum_ap - rep_w);
  assign pend_jog_w = sat(W'(pending_i) + delta);

  assign rep_o      = rep_w[POSITION_BITS-1:0];
  assign shift_o    = shift_w[POSITION_BITS-1:0];
  assign pend_jog_o = pend_jog_w[POSITION_BITS-1:0];

endmodule

// ----- hw/rtl/jslp_track.sv -----
// Tracking state and soft limit registers; applies one word per commit and
// forms its result word from the updated state.
// Depends on jslp_pkg and jslp_axis.
module jslp_track import jslp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                      commit_i,
  input  jslp_in_t                  item_i,
  output jslp_out_t                 result_o
);

  localparam int unsigned XW = (POSITION_BITS > 32) ? POSITION_BITS : 32;
  localparam int unsigned W  = XW + 2;
  localparam int unsigned CX = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic signed [W-1:0] PMAX =
    {{(W-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] PMIN =
    {{(W-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v > PMAX) begin
      r = PMAX;
    end else if (v < PMIN) begin
      r = PMIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [2:0]               lim_en_q, lim_en_d;
  logic signed [31:0]       limit_q [6];
  logic signed [31:0]       limit_d [6];
  logic                     track_q, track_d;
  logic                     conn_q, conn_d;
  logic                     jogging_q, jogging_d;
  logic signed [POSITION_BITS-1:0] anchor_q [3];
  logic signed [POSITION_BITS-1:0] anchor_d [3];
  logic signed [POSITION_BITS-1:0] pend_q [3];
  logic signed [POSITION_BITS-1:0] pend_d [3];
  logic [COUNT_BITS-1:0]    count_q, count_d;

  logic signed [31:0]              report [3];
  logic signed [31:0]              cmd [3];
  logic signed [POSITION_BITS-1:0] rep [3];
  logic signed [POSITION_BITS-1:0] shift [3];
  logic signed [POSITION_BITS-1:0] pend_jog [3];
  logic signed [31:0]              move [3];
  logic signed [W-1:0]             pred_w [3];
  logic [2:0]                      sent;
  logic [2:0]                      sent_mask;
  logic                            jog_ok, any_sent, moved, to_idle;
  logic [CX-1:0]                   count_ext;

  assign report[0] = item_i.report_x;
  assign report[1] = item_i.report_y;
  assign report[2] = item_i.report_z;
  assign cmd[0]    = item_i.jog_x;
  assign cmd[1]    = item_i.jog_y;
  assign cmd[2]    = item_i.jog_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    jslp_axis #(
      .POSITION_BITS(POSITION_BITS)
    ) u_axis (
      .anchor_i  (anchor_q[a]),
      .pending_i (pend_q[a]),
      .report_i  (report[a]),
      .cmd_i     (cmd[a]),
      .lim_a_i   (limit_q[2*a]),
      .lim_b_i   (limit_q[2*a+1]),
      .absolute_i(item_i.jog_absolute),
      .req_i     (item_i.axis_mask[a]),
      .lim_en_i  (lim_en_q[a]),
      .rep_o     (rep[a]),
      .shift_o   (shift[a]),
      .pend_jog_o(pend_jog[a]),
      .sent_o    (sent[a]),
      .move_o    (move[a])
    );
  end

  assign jog_ok    = (item_i.operation == OP_JOG) && conn_q;
  assign sent_mask = jog_ok ? sent : 3'b000;
  assign any_sent  = sent_mask != 3'b000;
  assign moved     = (rep[0] != anchor_q[0]) || (rep[1] != anchor_q[1]) ||
                     (rep[2] != anchor_q[2]);
  assign to_idle   = jogging_q && (item_i.machine_state == MS_IDLE);

  always_comb begin
    lim_en_d  = lim_en_q;
    limit_d   = limit_q;
    track_d   = track_q;
    conn_d    = conn_q;
    jogging_d = jogging_q;
    anchor_d  = anchor_q;
    pend_d    = pend_q;
    count_d   = count_q;
    if (cfg_we_i && (cfg_index_i <= REG_Z_HIGH)) begin
      case (cfg_index_i)
        REG_LIMIT_EN: lim_en_d   = cfg_data_i[2:0];
        REG_X_LOW:    limit_d[0] = cfg_data_i;
        REG_X_HIGH:   limit_d[1] = cfg_data_i;
        REG_Y_LOW:    limit_d[2] = cfg_data_i;
        REG_Y_HIGH:   limit_d[3] = cfg_data_i;
        REG_Z_LOW:    limit_d[4] = cfg_data_i;
        REG_Z_HIGH:   limit_d[5] = cfg_data_i;
        default:      lim_en_d   = lim_en_q;
      endcase
      for (int i = 0; i < 3; i++) begin
        pend_d[i] = '0;
      end
      count_d = '0;
      track_d = conn_q;
    end else if (commit_i) begin
      if (item_i.operation == OP_STATUS) begin
        if (!item_i.link_up) begin
          conn_d    = 1'b0;
          track_d   = 1'b0;
          jogging_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            anchor_d[i] = rep[i];
            pend_d[i]   = '0;
          end
        end else begin
          conn_d    = 1'b1;
          jogging_d = (item_i.machine_state == MS_JOGGING);
          if (!track_q || to_idle) begin
            for (int i = 0; i < 3; i++) begin
              anchor_d[i] = rep[i];
              pend_d[i]   = '0;
            end
            track_d = 1'b1;
            if (track_q) begin
              count_d = '0;
            end
          end else if (moved) begin
            // The machine has moved: keep the predicted end point and
            // retire one outstanding jog.
            for (int i = 0; i < 3; i++) begin
              anchor_d[i] = rep[i];
              pend_d[i]   = shift[i];
            end
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end
        end
      end else if (any_sent && track_q) begin
        for (int i = 0; i < 3; i++) begin
          if (sent_mask[i]) begin
            pend_d[i] = pend_jog[i];
          end
        end
        if (count_q != CNT_MAX) begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_en_q  <= '0;
      track_q   <= 1'b0;
      conn_q    <= 1'b0;
      jogging_q <= 1'b0;
      count_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        limit_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        anchor_q[i] <= '0;
        pend_q[i]   <= '0;
      end
    end else begin
      lim_en_q  <= lim_en_d;
      limit_q   <= limit_d;
      track_q   <= track_d;
      conn_q    <= conn_d;
      jogging_q <= jogging_d;
      anchor_q  <= anchor_d;
      pend_q    <= pend_d;
      count_q   <= count_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pred_w[i] = sat(W'(anchor_d[i]) + W'(pend_d[i]));
    end
  end

  assign count_ext = CX'(count_d);

  always_comb begin
    result_o                  = '0;
    result_o.accepted         = any_sent;
    result_o.sent_mask        = sent_mask;
    result_o.sent_absolute    = any_sent && item_i.jog_absolute;
    result_o.move_x           = sent_mask[0] ? move[0] : 32'sd0;
    result_o.move_y           = sent_mask[1] ? move[1] : 32'sd0;
    result_o.move_z           = sent_mask[2] ? move[2] : 32'sd0;
    result_o.feed_out         = any_sent ? item_i.feed_rate : 20'd0;
    result_o.pred_pos_x       = pred_w[0][31:0];
    result_o.pred_pos_y       = pred_w[1][31:0];
    result_o.pred_pos_z       = pred_w[2][31:0];
    result_o.pending_jobs     = count_ext[15:0];
    result_o.prediction_valid = track_d && conn_d;
  end

endmodule

// ----- hw/rtl/jog_soft_limit_predictor.sv -----
// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    jslp_in_t  (status report or jog command)
// out_o     out  valid/ready    jslp_out_t (one result per input word)
// cfg       in   cfg_we_i       cfg_index_i selects the register, cfg_data_i
//
// A word is held in the input register; its state update and result are
// committed together into the output register when it moves on.
// One word per cycle is sustained while out_o is ready; the throughput limit
// is the single tracking update per cycle. A stalled result holds the output
// register and backs up the input register only when both are full.
// Reset clears the tracking state, the limits and both pipeline valids.
// Top level of the jog soft limit predictor. Depends on jslp_pkg, the channel
// interfaces and jslp_track.
module jog_soft_limit_predictor import jslp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  jslp_in_if.sink                   in_i,
  jslp_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  logic      in_valid_q;
  jslp_in_t  in_data_q;
  logic      out_valid_q;
  jslp_out_t out_data_q;
  jslp_out_t result;
  logic      advance;

  // The input word moves on whenever the output register is free or drains.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  jslp_track #(
    .POSITION_BITS(POSITION_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .commit_i   (advance),
    .item_i     (in_data_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

// ----- hw/rtl/jslp_checker.sv -----
// Port-level checks of the jog soft limit predictor result channel,
// bound to the top level. Depends on jslp_pkg.
module jslp_checker import jslp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input jslp_out_t out_data
);

  // A stalled result word must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.accepted == (out_data.sent_mask != 3'b000))
    else $error("accepted flag disagrees with sent mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.sent_absolute |-> out_data.accepted)
    else $error("absolute flag on a jog that was not issued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.accepted |->
      out_data.feed_out == 20'd0 && out_data.move_x == 32'sd0 &&
      out_data.move_y == 32'sd0 && out_data.move_z == 32'sd0)
    else $error("move or feed fields set without an issued jog");

endmodule

bind jog_soft_limit_predictor jslp_checker u_jslp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_data (out_o.data)
);

// ----- bench/tb_jog_soft_limit_predictor.sv -----
// Self-checking bench for jog_soft_limit_predictor. A directed table runs first, then random
// status and jog words, checked against the bench's tracking model or, for typed rows, fixed results.
// Depends on jslp_pkg, jslp_in_if, jslp_out_if and the RTL top level.
`timescale 1ns / 100ps

module tb_jog_soft_limit_predictor;
  import jslp_pkg::*;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic [19:0] FEED_TOP = 20'd1000000;
  localparam longint POS_HI = (longint'(1) <<< (POSITION_BITS_DEF - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;
  localparam int unsigned JOBS_MAX = (1 << COUNT_BITS_DEF) - 1;
  localparam logic [1:0] MS_OTHER = 2'd0;
  localparam logic [1:0] MS_SPARE = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;
  localparam int PHASE_WORDS = 235;
  localparam int HOLD_CYCLES = 64;
  localparam int COUNT_FILL = 8;

  typedef struct packed {
    bit        has_typed;
    jslp_out_t word;
  } typed_check_t;

  typedef struct {
    jslp_in_t  word;
    bit        reconfig;
    bit        has_typed;
    jslp_out_t typed;
  } table_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  jslp_in_if  in_ch ();
  jslp_out_if out_ch ();

  jog_soft_limit_predictor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Tracking model state, mirrors the block after reset.
  logic [2:0]  trk_limit_en;
  longint      trk_limit [6];
  bit          trk_valid;
  bit          trk_link;
  bit          trk_jogging;
  longint      trk_anchor [3];
  longint      trk_offset [3];
  int unsigned trk_jobs;

  jslp_out_t         expected_results [$];
  typed_check_t      row_checks [$];
  table_row_t        directed_rows [$];
  logic signed [31:0] limit_plan [6];
  logic signed [31:0] last_report [3];
  int                mismatch_count;
  int                results_seen;
  bit                quiet_window;
  bit                hold_done;
  jslp_out_t         model_word;
  typed_check_t      pending_row;

  function automatic longint clip_position(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic longint clamp_to_window(input longint cur, tgt, lo, hi);
    longint t;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    // From outside the window only moves that head back toward it are allowed.
    if (cur < lo) return (tgt <= cur) ? cur : ((tgt > hi) ? hi : tgt);
    if (cur > hi) return (tgt >= cur) ? cur : ((tgt < lo) ? lo : tgt);
    return (tgt < lo) ? lo : ((tgt > hi) ? hi : tgt);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] val);
    if (idx == REG_LIMIT_EN) trk_limit_en = val[2:0];
    else if (idx <= REG_Z_HIGH) trk_limit[idx - REG_X_LOW] = longint'($signed(val));
    else return;
    for (int i = 0; i < 3; i++) trk_offset[i] = 0;
    trk_jobs = 0;
    trk_valid = trk_link;
  endfunction

  function automatic jslp_out_t advance_tracking(input jslp_in_t w);
    jslp_out_t  r;
    longint     rep [3];
    longint     cmd [3];
    longint     delta [3];
    longint     move [3];
    longint     pred;
    longint     tgt;
    logic [2:0] sent;
    bit         to_idle;
    bit         moved;
    r = '0;
    sent = '0;
    moved = 1'b0;
    rep[0] = w.report_x;
    rep[1] = w.report_y;
    rep[2] = w.report_z;
    cmd[0] = w.jog_x;
    cmd[1] = w.jog_y;
    cmd[2] = w.jog_z;
    for (int i = 0; i < 3; i++) begin
      delta[i] = 0;
      move[i] = 0;
    end
    if (w.operation == OP_STATUS) begin
      if (!w.link_up) begin
        trk_link = 1'b0;
        trk_valid = 1'b0;
        trk_jogging = 1'b0;
        for (int i = 0; i < 3; i++) begin
          trk_anchor[i] = rep[i];
          trk_offset[i] = 0;
        end
      end else begin
        to_idle = trk_jogging && (w.machine_state == MS_IDLE);
        trk_link = 1'b1;
        trk_jogging = (w.machine_state == MS_JOGGING);
        for (int i = 0; i < 3; i++) if (rep[i] != trk_anchor[i]) moved = 1'b1;
        if (!trk_valid || to_idle) begin
          for (int i = 0; i < 3; i++) begin
            trk_anchor[i] = rep[i];
            trk_offset[i] = 0;
          end
          if (trk_valid) trk_jobs = 0;
          trk_valid = 1'b1;
        end else if (moved) begin
          // Keep the same target while the reported position catches up.
          for (int i = 0; i < 3; i++) begin
            tgt = trk_anchor[i] + trk_offset[i];
            trk_anchor[i] = rep[i];
            trk_offset[i] = clip_position(tgt - rep[i]);
          end
          if (trk_jobs > 0) trk_jobs--;
        end
      end
    end else if (trk_link) begin
      for (int i = 0; i < 3; i++) begin
        if (w.axis_mask[i]) begin
          pred = clip_position(trk_anchor[i] + trk_offset[i]);
          tgt = clip_position(w.jog_absolute ? cmd[i] : pred + cmd[i]);
          if (trk_limit_en[i])
            tgt = clamp_to_window(pred, tgt, trk_limit[2*i], trk_limit[2*i+1]);
          if (tgt != pred) begin
            sent[i] = 1'b1;
            delta[i] = tgt - pred;
            move[i] = w.jog_absolute ? tgt : clip_position(tgt - pred);
          end
        end
      end
      if (sent != '0 && trk_valid) begin
        for (int i = 0; i < 3; i++)
          if (sent[i]) trk_offset[i] = clip_position(trk_offset[i] + delta[i]);
        if (trk_jobs < JOBS_MAX) trk_jobs++;
      end
    end
    r.accepted = |sent;
    r.sent_mask = sent;
    r.sent_absolute = |sent && w.jog_absolute;
    r.move_x = 32'(move[0]);
    r.move_y = 32'(move[1]);
    r.move_z = 32'(move[2]);
    r.feed_out = |sent ? w.feed_rate : '0;
    r.pred_pos_x = 32'(clip_position(trk_anchor[0] + trk_offset[0]));
    r.pred_pos_y = 32'(clip_position(trk_anchor[1] + trk_offset[1]));
    r.pred_pos_z = 32'(clip_position(trk_anchor[2] + trk_offset[2]));
    r.pending_jobs = 16'(trk_jobs);
    r.prediction_valid = trk_valid && trk_link;
    return r;
  endfunction

  function automatic void report_mismatch(input string what, input jslp_out_t exp,
                                          input jslp_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: result mismatch:%s expected %h got %h", $realtime, what, exp, got);
  endfunction

  function automatic void check_result(input jslp_out_t exp, input jslp_out_t got);
    string bad;
    bad = "";
    if (got.accepted !== exp.accepted) bad = {bad, " accepted"};
    if (got.sent_mask !== exp.sent_mask) bad = {bad, " sent_mask"};
    if (got.sent_absolute !== exp.sent_absolute) bad = {bad, " sent_absolute"};
    if (got.move_x !== exp.move_x) bad = {bad, " move_x"};
    if (got.move_y !== exp.move_y) bad = {bad, " move_y"};
    if (got.move_z !== exp.move_z) bad = {bad, " move_z"};
    if (got.feed_out !== exp.feed_out) bad = {bad, " feed_out"};
    if (got.pred_pos_x !== exp.pred_pos_x) bad = {bad, " pred_pos_x"};
    if (got.pred_pos_y !== exp.pred_pos_y) bad = {bad, " pred_pos_y"};
    if (got.pred_pos_z !== exp.pred_pos_z) bad = {bad, " pred_pos_z"};
    if (got.pending_jobs !== exp.pending_jobs) bad = {bad, " pending_jobs"};
    if (got.prediction_valid !== exp.prediction_valid) bad = {bad, " prediction_valid"};
    if (bad != "") report_mismatch(bad, exp, got);
  endfunction

  function automatic jslp_in_t status_word(input logic up, input logic [1:0] st,
                                           input logic signed [31:0] x, y, z);
    jslp_in_t w;
    w = '0;
    w.operation = OP_STATUS;
    w.link_up = up;
    w.machine_state = st;
    w.report_x = x;
    w.report_y = y;
    w.report_z = z;
    return w;
  endfunction

  function automatic jslp_in_t jog_word(input logic absolute, input logic [2:0] mask,
                                        input logic signed [31:0] x, y, z,
                                        input logic [19:0] feed);
    jslp_in_t w;
    w = '0;
    w.operation = OP_JOG;
    w.jog_absolute = absolute;
    w.axis_mask = mask;
    w.jog_x = x;
    w.jog_y = y;
    w.jog_z = z;
    w.feed_rate = feed;
    return w;
  endfunction

  function automatic jslp_out_t tracking_only(input logic signed [31:0] px, py, pz,
                                              input logic [15:0] jobs, input logic pv);
    jslp_out_t r;
    r = '0;
    r.pred_pos_x = px;
    r.pred_pos_y = py;
    r.pred_pos_z = pz;
    r.pending_jobs = jobs;
    r.prediction_valid = pv;
    return r;
  endfunction

  function automatic void add_row(input jslp_in_t w, input bit reconfig = 1'b0,
                                  input bit typed = 1'b0, input jslp_out_t exp = '0);
    table_row_t row;
    row.word = w;
    row.reconfig = reconfig;
    row.has_typed = typed;
    row.typed = exp;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [31:0] pick_position();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? POS_MAX : POS_MIN;
      default: return int'($urandom_range(60000)) - 30000;
    endcase
  endfunction

  function automatic jslp_in_t random_word();
    jslp_in_t w;
    w.operation = ($urandom_range(99) < 60) ? OP_JOG : OP_STATUS;
    w.link_up = ($urandom_range(99) < 90);
    w.machine_state = 2'($urandom_range(3));
    w.report_x = pick_position();
    w.report_y = pick_position();
    w.report_z = pick_position();
    w.jog_absolute = 1'($urandom_range(1));
    w.axis_mask = 3'($urandom_range(7));
    w.jog_x = pick_position();
    w.jog_y = pick_position();
    w.jog_z = pick_position();
    w.feed_rate = 20'($urandom_range(1000000));
    // Repeated reports let the tracking settle instead of re-anchoring every time.
    if (w.operation == OP_STATUS) begin
      if ($urandom_range(99) < 40) begin
        w.report_x = last_report[0];
        w.report_y = last_report[1];
        w.report_z = last_report[2];
      end
      last_report[0] = w.report_x;
      last_report[1] = w.report_y;
      last_report[2] = w.report_z;
    end
    return w;
  endfunction

  task automatic offer_word(input jslp_in_t w, input bit typed = 1'b0,
                            input jslp_out_t exp = '0);
    typed_check_t tc;
    tc.has_typed = typed;
    tc.word = exp;
    row_checks.push_back(tc);
    while (!quiet_window && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg_write(idx, val);
  endtask

  // Registers change only with the pipeline empty.
  task automatic load_limits(input logic [2:0] en, input bit spare);
    in_ch.valid <= 1'b0;
    drain_results();
    write_reg(REG_LIMIT_EN, 32'(en));
    for (int k = 0; k < 6; k++) write_reg(REG_X_LOW + 3'(k), limit_plan[k]);
    if (spare) write_reg(CFG_SPARE_INDEX, $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off that fills the block.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= quiet_window || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) report_mismatch(" unexpected word", '0, out_ch.data);
        else check_result(expected_results.pop_front(), out_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        model_word = advance_tracking(in_ch.data);
        pending_row = row_checks.pop_front();
        expected_results.push_back(pending_row.has_typed ? pending_row.word : model_word);
      end
    end
  end

  initial begin
    logic [2:0] en;
    jslp_out_t  exp_sat;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet_window = 1'b0;
    last_report = '{default: '0};

    // Reset state and saturation at the edges of the position range.
    add_row(jog_word(1'b1, 3'b111, 32'sd100, -32'sd100, 32'sd5, 20'd500), 1'b0, 1'b1,
            tracking_only(0, 0, 0, 16'd0, 1'b0));
    add_row(status_word(1'b0, MS_OTHER, POS_MIN, POS_MAX, -32'sd1), 1'b0, 1'b1,
            tracking_only(POS_MIN, POS_MAX, -32'sd1, 16'd0, 1'b0));
    add_row(status_word(1'b1, MS_IDLE, 0, 0, 0), 1'b0, 1'b1,
            tracking_only(0, 0, 0, 16'd0, 1'b1));
    exp_sat = tracking_only(POS_MAX, POS_MIN, 0, 16'd1, 1'b1);
    exp_sat.accepted = 1'b1;
    exp_sat.sent_mask = 3'b011;
    exp_sat.move_x = POS_MAX;
    exp_sat.move_y = POS_MIN;
    exp_sat.feed_out = FEED_TOP;
    add_row(jog_word(1'b0, 3'b111, POS_MAX, POS_MIN, 0, FEED_TOP), 1'b0, 1'b1, exp_sat);
    add_row(jog_word(1'b0, 3'b001, 32'sd1, 0, 0, 20'd10));
    add_row(jog_word(1'b1, 3'b111, POS_MIN, POS_MAX, 0, 20'd0));
    // Status handling: re-anchor, jogging to idle, unused machine states.
    add_row(status_word(1'b1, MS_JOGGING, 32'sd1000, -32'sd2000, 32'sd3));
    add_row(status_word(1'b1, MS_JOGGING, 32'sd1000, -32'sd2000, 32'sd3));
    add_row(status_word(1'b1, MS_IDLE, 32'sd5, 32'sd5, 32'sd5));
    add_row(status_word(1'b1, MS_SPARE, 32'sd5, 32'sd5, 32'sd5));
    add_row(status_word(1'b1, MS_OTHER, 32'sd7, 32'sd7, 32'sd7));
    add_row(jog_word(1'b0, 3'b000, 32'sd50, 32'sd50, 32'sd50, 20'd99));
    // Soft limits: reversed X ends, full-range Y, Z window above the position.
    add_row(jog_word(1'b0, 3'b001, 32'sd5000, 0, 0, 20'd1), 1'b1);
    add_row(jog_word(1'b0, 3'b100, 0, 0, -32'sd100, 20'd2));
    add_row(jog_word(1'b0, 3'b100, 0, 0, 32'sd30000, 20'd3));
    add_row(status_word(1'b1, MS_IDLE, 32'sd3000, 0, 32'sd30000));
    add_row(jog_word(1'b0, 3'b001, 32'sd100, 0, 0, 20'd4));
    add_row(jog_word(1'b0, 3'b001, -32'sd5000, 0, 0, 20'd5));
    add_row(jog_word(1'b1, 3'b111, 32'sd500, POS_MIN, 32'sd10000, 20'd6));
    add_row(jog_word(1'b1, 3'b100, 0, 0, POS_MAX, FEED_TOP));
    add_row(status_word(1'b0, MS_OTHER, 32'sd1, 32'sd2, 32'sd3));
    add_row(jog_word(1'b0, 3'b111, 32'sd10, 32'sd10, 32'sd10, 20'd7));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].reconfig) begin
        limit_plan = '{32'sd1000, -32'sd1000, POS_MIN, POS_MAX, 32'sd5000, 32'sd20000};
        load_limits(3'b111, 1'b1);
      end
      offer_word(directed_rows[r].word, directed_rows[r].has_typed, directed_rows[r].typed);
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          en = 3'b000;
          limit_plan = '{default: '0};
        end
        1: begin
          en = 3'b111;
          limit_plan = '{POS_MIN, POS_MAX, POS_MAX, POS_MIN, 32'sd0, 32'sd0};
        end
        default: begin
          en = (phase == 3) ? 3'b111 : 3'($urandom_range(7));
          foreach (limit_plan[k]) limit_plan[k] = pick_position();
        end
      endcase
      load_limits(en, phase == 0);
      // One whole phase runs with neither side idling.
      quiet_window = (phase == 4);
      for (int n = 0; n < PHASE_WORDS; n++) offer_word(random_word());
    end

    // Build up the outstanding count with small jogs, then retire one on a moved report.
    limit_plan = '{default: '0};
    load_limits(3'b000, 1'b0);
    quiet_window = 1'b1;
    offer_word(status_word(1'b0, MS_OTHER, 0, 0, 0));
    offer_word(status_word(1'b1, MS_IDLE, 0, 0, 0));
    for (int k = 0; k < COUNT_FILL; k++)
      offer_word(jog_word(1'b0, 3'b001, (k % 2) ? -32'sd1 : 32'sd1, 0, 0, 20'(k)));
    offer_word(status_word(1'b1, MS_OTHER, 32'sd9, 32'sd9, 32'sd9));
    quiet_window = 1'b0;

    in_ch.valid <= 1'b0;
    drain_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
